### rtl/gap_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gap_pkg: shared types and constants for the glyph atlas shelf packer
// Item, result and shelf state types, config indexes, sizing helpers.
// ----------------------------------------------------------------------------
package gap_pkg;

	localparam int MAX_ATLAS_HEIGHT_DEF = 4096;

	// config register indexes
	localparam logic CFG_FONT_PIXEL_SIZE = 1'b0;
	localparam logic CFG_GLYPH_PADDING   = 1'b1;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 10;

	localparam logic [9:0] FONT_PIXEL_SIZE_RST = 10'd16;
	localparam logic [5:0] GLYPH_PADDING_RST   = 6'd1;

	localparam logic [15:0] SAT13_MAX = 16'd8191;
	localparam logic [15:0] ROW_ROUND = 16'd255;
	localparam logic [15:0] ROW_MASK  = 16'hFF00;

	typedef struct packed {
		logic [15:0] glyph_id;
		logic [9:0]  glyph_width;
		logic [9:0]  glyph_height;
	} glyph_t;

	typedef struct packed {
		logic        placed;
		logic [15:0] glyph_tag;
		logic [12:0] region_left;
		logic [12:0] region_top;
		logic [9:0]  region_width;
		logic [9:0]  region_height;
		logic [12:0] atlas_rows;
	} region_t;

	typedef struct packed {
		logic        atlas_ready;
		logic [12:0] atlas_width;
		logic [13:0] atlas_height;
		logic [12:0] pen_x;
		logic [12:0] pen_y;
		logic [9:0]  shelf_height;
	} shelf_state_t;

	function automatic logic [12:0] sat13(input logic [15:0] v);
		return (v > SAT13_MAX) ? 13'h1FFF : v[12:0];
	endfunction

	// atlas width tier from font size
	function automatic logic [12:0] tier_width(input logic [9:0] fs);
		logic [12:0] w;
		if (fs <= 10'd16)       w = 13'd512;
		else if (fs <= 10'd32)  w = 13'd768;
		else if (fs <= 10'd48)  w = 13'd1024;
		else if (fs <= 10'd64)  w = 13'd1536;
		else if (fs <= 10'd256) w = 13'd2048;
		else                    w = 13'd4096;
		return w;
	endfunction

endpackage

### rtl/gap_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gap_stream_if: valid/ready request channel
// Carries one payload of type T per request.
// ----------------------------------------------------------------------------
interface gap_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### rtl/gap_place.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gap_place: shelf placement for one glyph
// Sizes the atlas on first use, wraps shelves, grows the height, checks limit.
// ----------------------------------------------------------------------------
module gap_place #(
	parameter int MAX_ATLAS_HEIGHT = gap_pkg::MAX_ATLAS_HEIGHT_DEF
) (
	input  gap_pkg::glyph_t       item,
	input  gap_pkg::shelf_state_t cur,
	input  logic [9:0]            font_pixel_size,
	input  logic [5:0]            glyph_padding,
	output gap_pkg::region_t      res,
	output gap_pkg::shelf_state_t nxt
);
	logic [12:0] width_e;
	logic [13:0] height_e;
	logic [12:0] pen_x1, pen_x2, pen_y2;
	logic [9:0]  shelf2;
	logic [15:0] reach, need, grown;
	logic        wrap, grow, fail;
	logic [13:0] height_n;

	always_comb begin
		if (cur.atlas_ready) begin
			width_e  = cur.atlas_width;
			height_e = cur.atlas_height;
		end else begin
			width_e  = gap_pkg::tier_width(font_pixel_size);
			height_e = (font_pixel_size <= 10'd256) ? 14'd256 : 14'd512;
		end

		pen_x1 = gap_pkg::sat13(16'(cur.pen_x) + 16'(glyph_padding));
		reach  = 16'(pen_x1) + 16'(item.glyph_width) + 16'(glyph_padding);
		wrap   = 16'(width_e) < reach;

		if (wrap) begin
			pen_x2 = 13'(glyph_padding);
			pen_y2 = gap_pkg::sat13(16'(cur.pen_y) + 16'(cur.shelf_height)
				+ 16'({glyph_padding, 1'b0}));
			shelf2 = '0;
		end else begin
			pen_x2 = pen_x1;
			pen_y2 = cur.pen_y;
			shelf2 = cur.shelf_height;
		end

		need  = 16'(pen_y2) + 16'(item.glyph_height) + 16'(glyph_padding);
		grown = (need + gap_pkg::ROW_ROUND) & gap_pkg::ROW_MASK;
		grow  = 16'(height_e) < need;
		fail  = grow && (16'(MAX_ATLAS_HEIGHT) < grown);
		height_n = (grow && !fail) ? grown[13:0] : height_e;

		res.placed        = !fail;
		res.glyph_tag     = item.glyph_id;
		res.region_left   = fail ? '0 : pen_x2;
		res.region_top    = fail ? '0 : pen_y2;
		res.region_width  = fail ? '0 : item.glyph_width;
		res.region_height = fail ? '0 : item.glyph_height;
		res.atlas_rows    = gap_pkg::sat13(16'(height_n));

		nxt.atlas_ready  = 1'b1;
		nxt.atlas_width  = width_e;
		nxt.atlas_height = height_n;
		nxt.pen_y        = pen_y2;
		if (fail) begin
			nxt.pen_x        = pen_x2;
			nxt.shelf_height = shelf2;
		end else begin
			nxt.pen_x = gap_pkg::sat13(16'(pen_x2) + 16'(item.glyph_width)
				+ 16'(glyph_padding));
			nxt.shelf_height = (item.glyph_height > shelf2) ? item.glyph_height : shelf2;
		end
	end
endmodule

### rtl/glyph_atlas_shelf_packer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_atlas_shelf_packer: shelf packer for a growing glyph atlas
// Places each glyph request on the current shelf and reports its region.
// ----------------------------------------------------------------------------
// Path: the request is held in the input register, then placement
//   writes the result register, which holds while stalled.
// Throughput: one glyph per cycle while the result is not stalled; the
//   pen state loop closes through the placement logic, so consecutive
//   glyphs never wait on it.
// Reset (arst_n low): atlas unsized, pen and shelf at zero, font size 16,
//   padding 1, both stages empty.
module glyph_atlas_shelf_packer #(
	parameter int MAX_ATLAS_HEIGHT = gap_pkg::MAX_ATLAS_HEIGHT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [gap_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [gap_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	gap_stream_if.sink                      glyph,
	gap_stream_if.source                    region
);
	// configuration
	logic [9:0] font_pixel_size_q;
	logic [5:0] glyph_padding_q;

	// input stage
	logic            valid_s1;
	gap_pkg::glyph_t item_s1;

	// result stage
	logic             valid_s2;
	gap_pkg::region_t result_s2;

	// packer state and next-state from placement
	gap_pkg::shelf_state_t state_q;
	gap_pkg::shelf_state_t state_nxt;
	gap_pkg::region_t      result_nxt;

	logic advance;

	// the input stage moves on whenever the result register is free or
	// being drained this cycle
	assign advance      = valid_s1 && (!valid_s2 || region.ready);
	assign glyph.ready  = !valid_s1 || advance;
	assign region.valid = valid_s2;
	assign region.data  = result_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			font_pixel_size_q <= gap_pkg::FONT_PIXEL_SIZE_RST;
			glyph_padding_q   <= gap_pkg::GLYPH_PADDING_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gap_pkg::CFG_FONT_PIXEL_SIZE: font_pixel_size_q <= cfg_wdata[9:0];
				gap_pkg::CFG_GLYPH_PADDING:   glyph_padding_q   <= cfg_wdata[5:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (glyph.valid && glyph.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (glyph.valid && glyph.ready) begin
			item_s1 <= glyph.data;
		end
	end

	gap_place #(
		.MAX_ATLAS_HEIGHT(MAX_ATLAS_HEIGHT)
	) u_place (
		.item           (item_s1),
		.cur            (state_q),
		.font_pixel_size(font_pixel_size_q),
		.glyph_padding  (glyph_padding_q),
		.res            (result_nxt),
		.nxt            (state_nxt)
	);

	// packer state commits together with the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			state_q  <= state_nxt;
			valid_s2 <= 1'b1;
		end else if (region.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_nxt;
		end
	end
endmodule

### rtl/gap_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gap_checker: port-level checks for the shelf packer
// Watches request and result channels; bound to the top level.
// ----------------------------------------------------------------------------
module gap_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        placed,
	input logic [12:0] region_left,
	input logic [12:0] region_top,
	input logic [9:0]  region_width,
	input logic [9:0]  region_height,
	input logic [12:0] atlas_rows
);
	logic [1:0]  inflight_q;
	logic [12:0] last_rows_q;
	logic        seen_q;
	logic        in_acc, out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
			seen_q     <= 1'b0;
		end else begin
			inflight_q <= inflight_q + 2'(in_acc) - 2'(out_acc);
			if (out_acc) seen_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_acc) last_rows_q <= atlas_rows;
	end

	// a stalled result keeps its rows figure
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(atlas_rows))
		else $error("result changed while stalled");

	// never more than two requests held inside
	a_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 2'd2)
		else $error("too many requests in flight");

	// a failed placement gives an empty region
	a_fail_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !placed |-> region_left == '0 && region_top == '0
			&& region_width == '0 && region_height == '0)
		else $error("failed placement with non-empty region");

	// atlas height never shrinks from one result to the next
	a_rows_grow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && seen_q |-> atlas_rows >= last_rows_q)
		else $error("atlas height shrank");
endmodule

bind glyph_atlas_shelf_packer gap_checker u_gap_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (glyph.valid),
	.in_ready     (glyph.ready),
	.out_valid    (region.valid),
	.out_ready    (region.ready),
	.placed       (region.data.placed),
	.region_left  (region.data.region_left),
	.region_top   (region.data.region_top),
	.region_width (region.data.region_width),
	.region_height(region.data.region_height),
	.atlas_rows   (region.data.atlas_rows)
);
